@@ design/density_cluster_from_distances_assert.svh @@
// ----------------------------------------------------------------------------
// density_cluster_from_distances assertion macros
// concurrent assertion shorthands, sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef DENSITY_CLUSTER_FROM_DISTANCES_ASSERT_SVH
`define DENSITY_CLUSTER_FROM_DISTANCES_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dcd_pkg
// shared types and constants of the density clustering block
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAXD_W     = 16;
  localparam int MINN_W     = 7;
  localparam int NODES_W    = 7;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_TOT_W  = 7;

  localparam logic [MAXD_W-1:0]  MAXD_RST  = 16'd10;
  localparam logic [MINN_W-1:0]  MINN_RST  = 7'd1;
  localparam logic [NODES_W-1:0] NODES_RST = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NBR_THRESH = 2'd0,
    REG_CORE_MIN   = 2'd1,
    REG_NODE_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [MAXD_W-1:0]  nbr_thresh;
    logic [MINN_W-1:0]  core_min;
    logic [NODES_W-1:0] node_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_NODE_RD,
    ST_NODE_LD,
    ST_SCAN,
    ST_CHK,
    ST_NODE_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_STREAM,
    OP_NODE_LD,
    OP_SCAN,
    OP_CHK,
    OP_NODE_WR,
    OP_EMIT_LD,
    OP_EMIT_NEXT
  } dp_op_t;

  typedef struct packed {
    logic matrix_end;
    logic node_skip;
    logic scan_bit;
    logic scan_more;
    logic chk_stop;
    logic last_node;
  } dp_status_t;

endpackage

@@ design/dcd_if.sv @@
// ----------------------------------------------------------------------------
// dcd_if
// valid/ready channels of the density clustering block
// ----------------------------------------------------------------------------
interface dcd_in_if #(
  parameter int DIST_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface dcd_out_if
  import dcd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] node_index;
  logic [OUT_IDX_W-1:0] neighbor_count;
  logic [OUT_IDX_W-1:0] cluster_id;
  logic [OUT_TOT_W-1:0] cluster_total;
  logic                 last_node;

  modport source (output valid, output node_index, output neighbor_count,
                  output cluster_id, output cluster_total, output last_node,
                  input ready);
  modport sink   (input valid, input node_index, input neighbor_count,
                  input cluster_id, input cluster_total, input last_node,
                  output ready);
endinterface

interface dcd_cfg_if
  import dcd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/dcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcd_ctrl
// sequencer for matrix load, clustering pass and result emission
// ----------------------------------------------------------------------------
module dcd_ctrl
  import dcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_op_t     op,
  output logic       in_ready,
  output logic       out_valid
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_STREAM;
          if (status.matrix_end) state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_NODE_RD;
      end
      ST_NODE_RD: begin
        state_nxt = ST_NODE_LD;
      end
      ST_NODE_LD: begin
        op        = OP_NODE_LD;
        state_nxt = status.node_skip ? ST_NODE_WR : ST_SCAN;
      end
      ST_SCAN: begin
        op = OP_SCAN;
        if (status.scan_bit) begin
          state_nxt = ST_CHK;
        end else if (!status.scan_more) begin
          state_nxt = ST_NODE_WR;
        end
      end
      ST_CHK: begin
        op        = OP_CHK;
        state_nxt = status.chk_stop ? ST_NODE_WR : ST_SCAN;
      end
      ST_NODE_WR: begin
        op        = OP_NODE_WR;
        state_nxt = status.last_node ? ST_EMIT_RD : ST_NODE_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        op        = OP_EMIT_LD;
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          op        = OP_EMIT_NEXT;
          state_nxt = status.last_node ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

@@ design/dcd_dp.sv @@
// ----------------------------------------------------------------------------
// dcd_dp
// adjacency and count memories, load counters, scan unit and result register
// ----------------------------------------------------------------------------
module dcd_dp
  import dcd_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int DIST_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  dp_op_t               op,
  input  logic [DIST_BITS-1:0] in_distance,
  output dp_status_t           status,
  output logic [OUT_IDX_W-1:0] out_node_index,
  output logic [OUT_IDX_W-1:0] out_neighbor_count,
  output logic [OUT_IDX_W-1:0] out_cluster_id,
  output logic [OUT_TOT_W-1:0] out_cluster_total,
  output logic                 out_last_node
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = NW + 1;

  // memories
  logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
  logic [NW-1:0]        rcnt_mem [MAX_NODES];
  logic [NW-1:0]        ccnt_mem [MAX_NODES];
  logic [NW-1:0]        clus_mem [MAX_NODES];

  logic [MAX_NODES-1:0] adj_rd_r;
  logic [NW-1:0]        rcnt_rd_r;
  logic [NW-1:0]        ccnt_rd_r;
  logic [NW-1:0]        clus_rd_r;
  logic [NW-1:0]        addr_r;
  logic [NW-1:0]        rd_addr;

  // column count valid bits
  logic [MAX_NODES-1:0] cvalid_r;

  // load side
  logic [NW-1:0]        row_r;
  logic [NW-1:0]        col_r;
  logic [MAX_NODES-1:0] row_buf_r;
  logic [NW-1:0]        row_cnt_r;
  logic                 s1_valid_r;
  logic [NW-1:0]        s1_col_r;
  logic                 s1_near_r;
  logic                 lw_en_r;
  logic [NW-1:0]        lw_addr_r;
  logic [NW-1:0]        lw_val_r;

  // clustering side
  logic [NCW-1:0]       n_r;
  logic [NW-1:0]        i_r;
  logic [NW-1:0]        j_r;
  logic [MAX_NODES-1:0] row_sh_r;
  logic [NW-1:0]        left_r;
  logic                 core_r;
  logic                 joined_r;
  logic [NW-1:0]        cand_r;
  logic [NCW-1:0]       clusters_r;

  logic [DIST_BITS-1:0] thr;
  logic                 near;
  logic [MAX_NODES-1:0] row_nxt;
  logic [NW-1:0]        rcnt_nxt;
  logic [NCW-1:0]       row_inc;
  logic                 row_end;
  logic [NODES_W-1:0]   n_clamp;
  logic [NCW-1:0]       n_use;
  logic [NW-1:0]        s1_base;
  logic [NW-1:0]        s1_new;
  logic [NW-1:0]        rc_v;
  logic [NW-1:0]        cc_v;
  logic [NW-1:0]        cnt_q;
  logic                 cnt_ge;
  logic                 take;
  logic                 last_i;
  logic                 scan_more;
  logic [MAX_NODES-1:0] scan_mask;

  assign thr  = DIST_BITS'(cfg.nbr_thresh);
  assign near = (in_distance <= thr);

  always_comb begin
    row_nxt        = row_buf_r;
    row_nxt[col_r] = near;
  end

  assign rcnt_nxt = row_cnt_r + NW'(near);
  assign row_inc  = NCW'(row_r) + NCW'(1);
  assign row_end  = (NCW'(col_r) + NCW'(1)) >= NCW'(row_r);

  always_comb begin
    n_clamp = cfg.node_count;
    if (cfg.node_count < NODES_W'(2)) begin
      n_clamp = NODES_W'(2);
    end else if (cfg.node_count > NODES_W'(MAX_NODES)) begin
      n_clamp = NODES_W'(MAX_NODES);
    end
  end

  assign n_use = NCW'(n_clamp);

  // column count read-modify-write, forwarded from the previous write
  assign s1_base = (lw_en_r && (lw_addr_r == s1_col_r)) ? lw_val_r :
                   (cvalid_r[s1_col_r] ? ccnt_rd_r : '0);
  assign s1_new  = s1_base + NW'(s1_near_r);

  // node 0 has no row of its own
  assign rc_v   = (addr_r == '0) ? '0 : rcnt_rd_r;
  assign cc_v   = cvalid_r[addr_r] ? ccnt_rd_r : '0;
  assign cnt_q  = rc_v + cc_v;
  assign cnt_ge = (MINN_W'(cnt_q) >= cfg.core_min);
  assign take   = core_r || cnt_ge;

  assign last_i    = ((NCW'(i_r) + NCW'(1)) == n_r);
  assign scan_more = ((row_sh_r >> 1) != '0);

  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      scan_mask[k] = (NCW'(k) < NCW'(i_r));
    end
  end

  always_comb begin
    status.matrix_end = row_end && (row_inc >= n_use);
    status.node_skip  = !(cnt_ge || (cnt_q != '0)) || ((adj_rd_r & scan_mask) == '0);
    status.scan_bit   = row_sh_r[0];
    status.scan_more  = scan_more;
    status.chk_stop   = take || (left_r == NW'(1)) || !scan_more;
    status.last_node  = last_i;
  end

  always_comb begin
    case (op)
      OP_STREAM: rd_addr = col_r;
      OP_SCAN:   rd_addr = j_r;
      default:   rd_addr = i_r;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    adj_rd_r  <= adj_mem[rd_addr];
    rcnt_rd_r <= rcnt_mem[rd_addr];
    ccnt_rd_r <= ccnt_mem[rd_addr];
    clus_rd_r <= clus_mem[rd_addr];
    addr_r    <= rd_addr;
    if ((op == OP_STREAM) && row_end) begin
      adj_mem[row_r]  <= row_nxt;
      rcnt_mem[row_r] <= rcnt_nxt;
    end
    if (s1_valid_r) begin
      ccnt_mem[s1_col_r] <= s1_new;
    end
    if (op == OP_NODE_WR) begin
      clus_mem[i_r] <= joined_r ? cand_r : i_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_col_r  <= col_r;
    s1_near_r <= near;
    lw_addr_r <= s1_col_r;
    lw_val_r  <= s1_new;
    if (op == OP_EMIT_LD) begin
      out_node_index     <= OUT_IDX_W'(i_r);
      out_neighbor_count <= OUT_IDX_W'(cnt_q);
      out_cluster_id     <= OUT_IDX_W'(clus_rd_r);
      out_cluster_total  <= last_i ? OUT_TOT_W'(clusters_r) : '0;
      out_last_node      <= last_i;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= NW'(1);
      col_r      <= '0;
      row_buf_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      lw_en_r    <= 1'b0;
      cvalid_r   <= '0;
      n_r        <= NCW'(MAX_NODES);
      i_r        <= '0;
      j_r        <= '0;
      row_sh_r   <= '0;
      left_r     <= '0;
      core_r     <= 1'b0;
      joined_r   <= 1'b0;
      cand_r     <= '0;
      clusters_r <= '0;
    end else begin
      s1_valid_r <= (op == OP_STREAM);
      lw_en_r    <= s1_valid_r;
      if (s1_valid_r) cvalid_r[s1_col_r] <= 1'b1;
      case (op)
        OP_STREAM: begin
          if (row_end) begin
            col_r     <= '0;
            row_buf_r <= '0;
            row_cnt_r <= '0;
            if (status.matrix_end) begin
              row_r      <= NW'(1);
              n_r        <= n_use;
              i_r        <= '0;
              clusters_r <= '0;
            end else begin
              row_r <= row_inc[NW-1:0];
            end
          end else begin
            col_r     <= col_r + NW'(1);
            row_buf_r <= row_nxt;
            row_cnt_r <= rcnt_nxt;
          end
        end
        OP_NODE_LD: begin
          core_r   <= cnt_ge;
          left_r   <= cnt_q;
          row_sh_r <= adj_rd_r & scan_mask;
          j_r      <= '0;
          joined_r <= 1'b0;
        end
        OP_SCAN: begin
          if (!row_sh_r[0]) begin
            row_sh_r <= row_sh_r >> 1;
            j_r      <= j_r + NW'(1);
          end
        end
        OP_CHK: begin
          if (take) begin
            cand_r   <= clus_rd_r;
            joined_r <= 1'b1;
          end else begin
            left_r <= left_r - NW'(1);
          end
          row_sh_r <= row_sh_r >> 1;
          j_r      <= j_r + NW'(1);
        end
        OP_NODE_WR: begin
          if (!joined_r) clusters_r <= clusters_r + NCW'(1);
          i_r <= last_i ? '0 : i_r + NW'(1);
        end
        OP_EMIT_NEXT: begin
          if (last_i) begin
            cvalid_r <= '0;
            i_r      <= '0;
          end else begin
            i_r <= i_r + NW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/density_cluster_from_distances.sv @@
// one lower-triangle entry is taken per cycle while a matrix loads
// after the entry that closes the last row: flush, then per node i read, load,
//   a scan step per earlier position, a check per earlier neighbor, and write;
//   each result then passes read, load and wait states, leaving when the sink
//   is ready; no entry is taken from a matrix's end until its last result is taken
// reset (rst_n low, synchronous): registers to defaults, load position row 1 col 0
// ----------------------------------------------------------------------------
// density_cluster_from_distances
// streamed distance matrix in, simplified dbscan cluster assignment out
// ----------------------------------------------------------------------------
module density_cluster_from_distances
  import dcd_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int DIST_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  dcd_in_if.sink   in_ch,
  dcd_out_if.source out_ch,
  dcd_cfg_if.sink  cfg_ch
);

  // configuration registers, always ready
  logic [MAXD_W-1:0]  nbr_thresh_r;
  logic [MINN_W-1:0]  core_min_r;
  logic [NODES_W-1:0] node_count_r;
  cfg_t               cfg;

  dp_op_t     op;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbr_thresh_r <= MAXD_RST;
      core_min_r   <= MINN_RST;
      node_count_r <= NODES_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_NBR_THRESH: nbr_thresh_r <= cfg_ch.data[MAXD_W-1:0];
        REG_CORE_MIN:   core_min_r   <= cfg_ch.data[MINN_W-1:0];
        REG_NODE_COUNT: node_count_r <= cfg_ch.data[NODES_W-1:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  assign cfg.nbr_thresh = nbr_thresh_r;
  assign cfg.core_min   = core_min_r;
  assign cfg.node_count = node_count_r;

  // sequencer: load, flush, per-node scan, emission
  dcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .op        (op),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // memories, counters and the result register
  dcd_dp #(
    .MAX_NODES (MAX_NODES),
    .DIST_BITS (DIST_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .op                 (op),
    .in_distance        (in_ch.distance),
    .status             (status),
    .out_node_index     (out_ch.node_index),
    .out_neighbor_count (out_ch.neighbor_count),
    .out_cluster_id     (out_ch.cluster_id),
    .out_cluster_total  (out_ch.cluster_total),
    .out_last_node      (out_ch.last_node)
  );

  // an input transaction completes only in the load state
  assign in_ch.ready  = in_ready;
  // the result register is shown for as long as the sink stalls
  assign out_ch.valid = out_valid;

endmodule

@@ design/dcd_checker.sv @@
// ----------------------------------------------------------------------------
// dcd_checker
// port-level checks of the density clustering block, bound to the top level
// ----------------------------------------------------------------------------
`include "density_cluster_from_distances_assert.svh"

module dcd_checker
  import dcd_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_IDX_W-1:0] out_node_index,
  input logic [OUT_IDX_W-1:0] out_cluster_id,
  input logic [OUT_TOT_W-1:0] out_cluster_total,
  input logic                 out_last_node
);

  `DCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn while stalled")
  `DCD_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken during emission")
  `DCD_ASSERT_NEXT(a_reload, out_valid && out_ready && out_last_node, in_ready, "no reload after last result")
  `DCD_ASSERT_NOW(a_total_last, out_valid && !out_last_node, out_cluster_total == '0, "total before last result")
  `DCD_ASSERT_NOW(a_founder, out_valid, out_cluster_id <= out_node_index, "founder after its member")

endmodule

bind density_cluster_from_distances dcd_checker u_dcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_node_index    (out_ch.node_index),
  .out_cluster_id    (out_ch.cluster_id),
  .out_cluster_total (out_ch.cluster_total),
  .out_last_node     (out_ch.last_node)
);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// density clustering testbench
// streams lower-triangle distance matrices into the block and checks every
// per-node report against a typed-in report or a local predictor of the threshold,
// neighbor count and ordered cluster assignment, under several sender and sink pacings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import dcd_pkg::*;

  localparam int DIST_BITS     = 16;
  localparam int MAX_NODES     = 64;
  localparam int RAND_ITEMS    = 90;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  // a few hundred entries and passes of at most 12 nodes, all under random
  // gaps and stalls, taken many times over
  localparam int CYCLE_LIMIT   = 100000;

  typedef logic [DIST_BITS-1:0] dist_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] node_index;
    logic [OUT_IDX_W-1:0] neighbor_count;
    logic [OUT_IDX_W-1:0] cluster_id;
    logic [OUT_TOT_W-1:0] cluster_total;
    logic                 last_node;
  } node_report_t;

  // directed rows: register write, entry checked by the predictor, entry whose
  // reports are typed in by the rows that follow it, and one typed report
  typedef enum {ROW_CFG, ROW_DIST, ROW_DIST_TYPED, ROW_REPORT} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    cfg_reg_t     reg_idx;
    logic [15:0]  value;
    node_report_t report;
  } dir_row_t;

  typedef enum {PACE_FREE, PACE_SENDER, PACE_SINK, PACE_BOTH} pacing_t;

  localparam node_report_t NO_REPORT = '0;
  localparam int NUM_DIRECTED = 46;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // node count 0 acts as 2: one entry per matrix, on the threshold
    '{ROW_CFG,        REG_NODE_COUNT, 16'd0,     NO_REPORT},
    '{ROW_DIST_TYPED, REG_NBR_THRESH, 16'd10,    NO_REPORT},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd0, 6'd1, 6'd0, 7'd0, 1'b0}},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd1, 6'd1, 6'd0, 7'd1, 1'b1}},
    // one above the threshold: two lone nodes, two clusters
    '{ROW_DIST_TYPED, REG_NBR_THRESH, 16'd11,    NO_REPORT},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd0, 6'd0, 6'd0, 7'd0, 1'b0}},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd1, 6'd0, 6'd1, 7'd2, 1'b1}},
    // node count 1 acts as 2, zero threshold against both distance extremes
    '{ROW_CFG,        REG_NODE_COUNT, 16'd1,     NO_REPORT},
    '{ROW_CFG,        REG_NBR_THRESH, 16'd0,     NO_REPORT},
    '{ROW_DIST_TYPED, REG_NBR_THRESH, 16'd0,     NO_REPORT},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd0, 6'd1, 6'd0, 7'd0, 1'b0}},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd1, 6'd1, 6'd0, 7'd1, 1'b1}},
    '{ROW_DIST_TYPED, REG_NBR_THRESH, 16'hFFFF,  NO_REPORT},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd0, 6'd0, 6'd0, 7'd0, 1'b0}},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd1, 6'd0, 6'd1, 7'd2, 1'b1}},
    // full threshold and core minimum 0: every node core, one cluster
    '{ROW_CFG,        REG_NBR_THRESH, 16'hFFFF,  NO_REPORT},
    '{ROW_CFG,        REG_CORE_MIN,   16'd0,     NO_REPORT},
    '{ROW_CFG,        REG_NODE_COUNT, 16'd3,     NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'hFFFF,  NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd0,     NO_REPORT},
    '{ROW_DIST_TYPED, REG_NBR_THRESH, 16'hFFFF,  NO_REPORT},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd0, 6'd2, 6'd0, 7'd0, 1'b0}},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd1, 6'd2, 6'd0, 7'd0, 1'b0}},
    '{ROW_REPORT,     REG_NBR_THRESH, 16'd0,     '{6'd2, 6'd2, 6'd0, 7'd1, 1'b1}},
    // core minimum 127: no core node, scans run out on the neighbor count
    '{ROW_CFG,        REG_CORE_MIN,   16'd127,   NO_REPORT},
    '{ROW_CFG,        REG_NBR_THRESH, 16'd100,   NO_REPORT},
    '{ROW_CFG,        REG_NODE_COUNT, 16'd4,     NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd5,     NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd200,   NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd100,   NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd101,   NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd7,     NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd50,    NO_REPORT},
    // mixed core and non-core nodes joining earlier clusters
    '{ROW_CFG,        REG_CORE_MIN,   16'd2,     NO_REPORT},
    '{ROW_CFG,        REG_NBR_THRESH, 16'd1000,  NO_REPORT},
    '{ROW_CFG,        REG_NODE_COUNT, 16'd5,     NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd500,   NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd2000,  NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd999,   NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd1000,  NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd1001,  NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd3000,  NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'hFFFF,  NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd0,     NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd1500,  NO_REPORT},
    '{ROW_DIST,       REG_NBR_THRESH, 16'd800,   NO_REPORT}
  };

  logic clk;
  logic rst_n;

  dcd_in_if #(.DIST_BITS(DIST_BITS)) in_ch ();
  dcd_out_if  out_ch ();
  dcd_cfg_if  cfg_ch ();

  density_cluster_from_distances #(
    .MAX_NODES(MAX_NODES),
    .DIST_BITS(DIST_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // predictor state: adjacency, neighbor counts, cluster founders, load position
  logic [MAX_NODES-1:0] adj_rows   [MAX_NODES];
  logic [5:0]           nbr_counts [MAX_NODES];
  logic [5:0]           founder_of [MAX_NODES];
  int unsigned          load_row;
  int unsigned          load_col;
  logic [MAXD_W-1:0]    thr_q;
  logic [MINN_W-1:0]    core_min_q;
  logic [NODES_W-1:0]   nodes_q;

  node_report_t pending_nodes [$];  // reports still owed by the block
  node_report_t fresh_reports [$];  // reports of the last clustering pass

  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned rand_items;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // out-of-range node counts clamp to the legal range
  function automatic int unsigned nodes_in_matrix();
    return (nodes_q < 2) ? 2 : (nodes_q > MAX_NODES) ? MAX_NODES : int'(nodes_q);
  endfunction

  // ordered cluster pass, one report per node into fresh_reports
  function automatic void assign_clusters(input int unsigned n);
    int unsigned  i;
    int unsigned  j;
    int unsigned  c;
    int unsigned  left;
    int unsigned  found;
    node_report_t rpt;
    found = 0;
    for (i = 0; i < n; i++) begin
      c = i;
      if (nbr_counts[i] >= core_min_q) begin
        // core: first earlier neighbor decides
        for (j = 0; j < i; j++) begin
          if (adj_rows[i][j]) begin
            c = founder_of[j];
            break;
          end
        end
      end else if (nbr_counts[i] != 0) begin
        // non-core: first earlier core neighbor, budget of own neighbor count
        left = nbr_counts[i];
        for (j = 0; j < i; j++) begin
          if (adj_rows[i][j]) begin
            if (nbr_counts[j] >= core_min_q) begin
              c = founder_of[j];
              break;
            end
            left--;
            if (left == 0) break;
          end
        end
      end
      if (c == i) found++;
      founder_of[i] = c[5:0];
    end
    for (i = 0; i < n; i++) begin
      rpt.node_index     = OUT_IDX_W'(i);
      rpt.neighbor_count = nbr_counts[i];
      rpt.cluster_id     = founder_of[i];
      rpt.cluster_total  = (i + 1 == n) ? OUT_TOT_W'(found) : '0;
      rpt.last_node      = (i + 1 == n);
      fresh_reports.push_back(rpt);
    end
    for (i = 0; i < MAX_NODES; i++) nbr_counts[i] = '0;
    load_row = 1;
    load_col = 0;
  endfunction

  // one accepted matrix entry: mark the pair, count both ends, close rows
  function automatic void absorb_distance(input dist_t d);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    n = nodes_in_matrix();
    r = load_row % MAX_NODES;
    c = load_col & 63;
    if (d <= thr_q) begin
      adj_rows[r][c] = 1'b1;
      nbr_counts[r]  = nbr_counts[r] + 6'd1;
      nbr_counts[c]  = nbr_counts[c] + 6'd1;
    end else begin
      adj_rows[r][c] = 1'b0;
    end
    load_col = c + 1;
    if (load_col >= r) begin
      load_col = 0;
      load_row = r + 1;
      if (load_row >= n) assign_clusters(n);
    end
  endfunction

  function automatic void set_pacing(input pacing_t mode);
    send_idle_pct  = (mode == PACE_SENDER) ? 58 : (mode == PACE_BOTH) ? 8 : 0;
    sink_stall_pct = (mode == PACE_SINK)   ? 58 : (mode == PACE_BOTH) ? 8 : 0;
  endfunction

  // register writes only once the block has drained its reports
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_nodes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_NBR_THRESH: thr_q      = val[MAXD_W-1:0];
      REG_CORE_MIN:   core_min_q = val[MINN_W-1:0];
      REG_NODE_COUNT: nodes_q    = val[NODES_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one entry transaction; valid stays high into the next call when no gap
  task automatic send_distance(input dist_t d, input bit results_typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.distance <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fresh_reports.delete();
    absorb_distance(d);
    if (!results_typed) begin
      foreach (fresh_reports[k]) pending_nodes.push_back(fresh_reports[k]);
    end
    @(negedge clk);
  endtask

  // a whole matrix of random entries, mostly within span so both sides of
  // the threshold get hit, sometimes anywhere in the 16-bit range
  task automatic send_matrix(input int unsigned span);
    int unsigned n;
    dist_t       d;
    n = nodes_in_matrix();
    for (int unsigned k = 0; k < n * (n - 1) / 2; k++) begin
      d = ($urandom_range(0, 7) == 0) ? dist_t'($urandom_range(0, 65535))
                                      : dist_t'($urandom_range(0, span));
      send_distance(d, 1'b0);
      rand_items++;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
      fail_count++;
    end
  endfunction

  // sink ready, stalling at the phase's rate
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // report checker: every accepted transaction against the oldest expectation
  always @(posedge clk) begin
    node_report_t exp_rpt;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_nodes.size() == 0) begin
        $error("unexpected report for node %0d", out_ch.node_index);
        fail_count++;
      end else begin
        exp_rpt = pending_nodes.pop_front();
        check_field("node_index",     exp_rpt.node_index,     out_ch.node_index);
        check_field("neighbor_count", exp_rpt.neighbor_count, out_ch.neighbor_count);
        check_field("cluster_id",     exp_rpt.cluster_id,     out_ch.cluster_id);
        check_field("cluster_total",  exp_rpt.cluster_total,  out_ch.cluster_total);
        check_field("last_node",      exp_rpt.last_node,      out_ch.last_node);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned span;
    int unsigned phase;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.distance = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_NBR_THRESH;
    cfg_ch.data    = '0;
    fail_count     = 0;
    cycle_count    = 0;
    rand_items     = 0;
    set_pacing(PACE_BOTH);

    // predictor mirrors the reset state
    for (int i = 0; i < MAX_NODES; i++) begin
      adj_rows[i]   = '0;
      nbr_counts[i] = '0;
      founder_of[i] = '0;
    end
    load_row   = 1;
    load_col   = 0;
    thr_q      = MAXD_RST;
    core_min_q = MINN_RST;
    nodes_q    = NODES_RST;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_rows[k]) begin
      case (directed_rows[k].kind)
        ROW_CFG:        write_reg(directed_rows[k].reg_idx, directed_rows[k].value);
        ROW_DIST:       send_distance(directed_rows[k].value, 1'b0);
        ROW_DIST_TYPED: send_distance(directed_rows[k].value, 1'b1);
        ROW_REPORT:     pending_nodes.push_back(directed_rows[k].report);
        default: ;
      endcase
    end

    // random phases: new settings and pacing per phase, small matrices
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      set_pacing(pacing_t'(phase % 4));
      case ($urandom_range(0, 3))
        0:       span = 15;
        1:       span = 255;
        2:       span = 4095;
        default: span = 65535;
      endcase
      write_reg(REG_NBR_THRESH, CFG_DATA_W'($urandom_range(0, span)));
      write_reg(REG_CORE_MIN, ($urandom_range(0, 7) == 0)
                              ? CFG_DATA_W'($urandom_range(6, 127))
                              : CFG_DATA_W'($urandom_range(0, 5)));
      write_reg(REG_NODE_COUNT, ($urandom_range(0, 9) == 0)
                                ? CFG_DATA_W'($urandom_range(0, 1))
                                : CFG_DATA_W'($urandom_range(2, 12)));
      repeat ($urandom_range(1, 3)) send_matrix(span);
      phase++;
    end

    // one 12 node matrix, every pair neighbors, nothing core: counts of 11,
    // every node its own cluster and a total of 12
    set_pacing(PACE_SINK);
    write_reg(REG_NBR_THRESH, 16'hFFFF);
    write_reg(REG_CORE_MIN, 16'd12);
    write_reg(REG_NODE_COUNT, 16'd12);
    send_matrix(65535);

    // drain
    in_ch.valid <= 1'b0;
    while (pending_nodes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
